@@ hdl/free_list_first_fit_allocator_unit_assert.svh @@
// Assertion macros shared by the checker.
`ifndef FREE_LIST_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FFFA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define FFFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ hdl/fffa_pkg.sv @@
`default_nettype none

package fffa_pkg;

  localparam int unsigned CAPACITY_DEFAULT     = 64;
  localparam int unsigned ADDRESS_BITS_DEFAULT = 48;
  localparam int unsigned SIZE_BITS_DEFAULT    = 24;

  localparam int unsigned OPCODE_BITS     = 3;
  localparam int unsigned STATUS_BITS     = 2;
  localparam int unsigned TOTAL_BITS      = 31;
  localparam int unsigned FREE_TOTAL_BITS = 30;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_FREE         = 3'd0,
    OP_OBTAIN_SMALL = 3'd1,
    OP_OBTAIN_LARGE = 3'd2,
    OP_LOOKUP_SMALL = 3'd3,
    OP_LOOKUP_LARGE = 3'd4,
    OP_REBUILD      = 3'd5
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MOVE_HOLD = 2'd0,
    MOVE_PUSH = 2'd1,
    MOVE_PULL = 2'd2
  } move_t;

  typedef struct packed {
    logic  sample;
    move_t move;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ hdl/fffa_cell.sv @@
`default_nettype none

module fffa_cell #(
  parameter int unsigned ADDRESS_BITS = fffa_pkg::ADDRESS_BITS_DEFAULT,
  parameter int unsigned SIZE_BITS    = fffa_pkg::SIZE_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire fffa_pkg::cell_ctl_t     ctl,
  input  wire logic                    occupied,
  input  wire logic [SIZE_BITS-1:0]    req_size,
  input  wire logic [ADDRESS_BITS-1:0] prev_address,
  input  wire logic [SIZE_BITS-1:0]    prev_size,
  input  wire logic [ADDRESS_BITS-1:0] next_address,
  input  wire logic [SIZE_BITS-1:0]    next_size,
  output logic      [ADDRESS_BITS-1:0] address,
  output logic      [SIZE_BITS-1:0]    size,
  output logic                         fit
);

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      fit <= occupied && (size >= req_size);
    end
    case (ctl.move)
      fffa_pkg::MOVE_PUSH: begin
        address <= prev_address;
        size    <= prev_size;
      end
      fffa_pkg::MOVE_PULL: begin
        address <= next_address;
        size    <= next_size;
      end
      default: begin
        address <= address;
        size    <= size;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/fffa_pick.sv @@
`default_nettype none

module fffa_pick #(
  parameter int unsigned CAPACITY     = fffa_pkg::CAPACITY_DEFAULT,
  parameter int unsigned ADDRESS_BITS = fffa_pkg::ADDRESS_BITS_DEFAULT,
  parameter int unsigned SIZE_BITS    = fffa_pkg::SIZE_BITS_DEFAULT
) (
  input  wire logic [CAPACITY-1:0]     fit,
  input  wire logic [ADDRESS_BITS-1:0] cell_address [CAPACITY],
  input  wire logic [SIZE_BITS-1:0]    cell_size [CAPACITY],
  output logic                         hit,
  output logic      [CAPACITY-1:0]     tail_mask,
  output logic      [ADDRESS_BITS-1:0] address,
  output logic      [SIZE_BITS-1:0]    size
);

  logic [CAPACITY-1:0] first;

  // lowest set bit is the newest fitting block
  always_comb begin
    hit       = |fit;
    first     = fit & (~fit + CAPACITY'(1));
    tail_mask = ~(first - CAPACITY'(1));
    address   = '0;
    size      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      address = address | ({ADDRESS_BITS{first[i]}} & cell_address[i]);
      size    = size    | ({SIZE_BITS{first[i]}} & cell_size[i]);
    end
  end

endmodule

`default_nettype wire

@@ hdl/free_list_first_fit_allocator_unit.sv @@
// Flow: the cell row compares when an input is accepted, then selects and shifts at commit.
// One item in flight: a new input is taken only after the last result commits, and
// a stalled result holds the select and shift step.
// Reset: clears state machine, output valid, block count and free byte total.
// Cell contents are not cleared; only cells below the count are ever read.
`default_nettype none

module free_list_first_fit_allocator_unit #(
  parameter int unsigned CAPACITY     = fffa_pkg::CAPACITY_DEFAULT,
  parameter int unsigned ADDRESS_BITS = fffa_pkg::ADDRESS_BITS_DEFAULT,
  parameter int unsigned SIZE_BITS    = fffa_pkg::SIZE_BITS_DEFAULT,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1),
  localparam int unsigned IN_RAW  = fffa_pkg::OPCODE_BITS + ADDRESS_BITS + SIZE_BITS,
  localparam int unsigned IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = fffa_pkg::STATUS_BITS + ADDRESS_BITS + SIZE_BITS
                                    + fffa_pkg::FREE_TOTAL_BITS + CNT_W,
  localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // opcode, block_address, block_size
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // status, found_address, found_size, free_total, entry_total
  output logic      [OUT_W-1:0] m_tdata
);

  localparam int unsigned TOTAL_BITS = fffa_pkg::TOTAL_BITS;
  localparam int unsigned CMP_W = (TOTAL_BITS > SIZE_BITS) ? TOTAL_BITS : SIZE_BITS;

  fffa_pkg::state_t state;
  fffa_pkg::op_t    op;
  logic [ADDRESS_BITS-1:0] req_address;
  logic [SIZE_BITS-1:0]    req_size;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [TOTAL_BITS-1:0]   bytes_free;
  logic [TOTAL_BITS-1:0]   bytes_free_next;

  logic [ADDRESS_BITS-1:0] cell_address [CAPACITY];
  logic [SIZE_BITS-1:0]    cell_size [CAPACITY];
  logic [CAPACITY-1:0]     fit;
  logic [CAPACITY-1:0]     occupied;
  fffa_pkg::cell_ctl_t     ctl [CAPACITY];

  logic [CAPACITY-1:0]     search_fit;
  logic                    pick_hit;
  logic [CAPACITY-1:0]     tail_mask;
  logic [ADDRESS_BITS-1:0] pick_address;
  logic [SIZE_BITS-1:0]    pick_size;

  logic                    accept;
  logic                    commit;
  logic                    found;
  logic                    push;
  logic                    pull;
  fffa_pkg::status_t       status;
  logic [ADDRESS_BITS-1:0] found_address;
  logic [SIZE_BITS-1:0]    found_size;

  assign s_tready = (state == fffa_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == fffa_pkg::ST_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    if ((op == fffa_pkg::OP_OBTAIN_SMALL) || (op == fffa_pkg::OP_LOOKUP_SMALL)) begin
      search_fit = fit & CAPACITY'(1);
    end else begin
      search_fit = fit;
    end
  end

  fffa_pick #(
    .CAPACITY    (CAPACITY),
    .ADDRESS_BITS(ADDRESS_BITS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_pick (
    .fit         (search_fit),
    .cell_address(cell_address),
    .cell_size   (cell_size),
    .hit         (pick_hit),
    .tail_mask   (tail_mask),
    .address     (pick_address),
    .size        (pick_size)
  );

  always_comb begin
    status          = fffa_pkg::STATUS_OK;
    found           = 1'b0;
    push            = 1'b0;
    pull            = 1'b0;
    count_next      = count;
    bytes_free_next = bytes_free;
    case (op)
      fffa_pkg::OP_FREE: begin
        if (count == CNT_W'(CAPACITY)) begin
          status = fffa_pkg::STATUS_FULL;
        end else begin
          push            = 1'b1;
          count_next      = count + CNT_W'(1);
          bytes_free_next = bytes_free + TOTAL_BITS'(req_size);
        end
      end
      fffa_pkg::OP_OBTAIN_SMALL, fffa_pkg::OP_OBTAIN_LARGE,
      fffa_pkg::OP_LOOKUP_SMALL, fffa_pkg::OP_LOOKUP_LARGE: begin
        found = pick_hit;
        if ((op == fffa_pkg::OP_LOOKUP_LARGE) &&
            (CMP_W'(bytes_free) < CMP_W'(req_size))) begin
          found = 1'b0;
        end
        if (!found) begin
          status = fffa_pkg::STATUS_NO_FIT;
        end else if ((op == fffa_pkg::OP_OBTAIN_SMALL) ||
                     (op == fffa_pkg::OP_OBTAIN_LARGE)) begin
          pull            = 1'b1;
          count_next      = count - CNT_W'(1);
          bytes_free_next = bytes_free - TOTAL_BITS'(pick_size);
        end
      end
      fffa_pkg::OP_REBUILD: begin
        count_next      = '0;
        bytes_free_next = '0;
      end
      default: begin
        status = fffa_pkg::STATUS_OK;
      end
    endcase
    found_address = found ? pick_address : '0;
    found_size    = found ? pick_size : '0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ADDRESS_BITS-1:0] prev_address;
    logic [SIZE_BITS-1:0]    prev_size;
    logic [ADDRESS_BITS-1:0] next_address;
    logic [SIZE_BITS-1:0]    next_size;

    assign occupied[i] = CNT_W'(i) < count;

    always_comb begin
      ctl[i].sample = accept;
      if (commit && push) begin
        ctl[i].move = fffa_pkg::MOVE_PUSH;
      end else if (commit && pull && tail_mask[i]) begin
        ctl[i].move = fffa_pkg::MOVE_PULL;
      end else begin
        ctl[i].move = fffa_pkg::MOVE_HOLD;
      end
    end

    if (i == 0) begin : g_front
      assign prev_address = req_address;
      assign prev_size    = req_size;
    end else begin : g_inner
      assign prev_address = cell_address[i-1];
      assign prev_size    = cell_size[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign next_address = '0;
      assign next_size    = '0;
    end else begin : g_body
      assign next_address = cell_address[i+1];
      assign next_size    = cell_size[i+1];
    end

    fffa_cell #(
      .ADDRESS_BITS(ADDRESS_BITS),
      .SIZE_BITS   (SIZE_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .occupied    (occupied[i]),
      .req_size    (s_tdata[IN_RAW-1 -: SIZE_BITS]),
      .prev_address(prev_address),
      .prev_size   (prev_size),
      .next_address(next_address),
      .next_size   (next_size),
      .address     (cell_address[i]),
      .size        (cell_size[i]),
      .fit         (fit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fffa_pkg::ST_IDLE;
      m_tvalid   <= 1'b0;
      count      <= '0;
      bytes_free <= '0;
    end else begin
      case (state)
        fffa_pkg::ST_IDLE: begin
          if (accept) begin
            state <= fffa_pkg::ST_EXEC;
          end
        end
        fffa_pkg::ST_EXEC: begin
          if (commit) begin
            state <= fffa_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= fffa_pkg::ST_IDLE;
        end
      endcase
      if (commit) begin
        m_tvalid   <= 1'b1;
        count      <= count_next;
        bytes_free <= bytes_free_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= fffa_pkg::op_t'(s_tdata[fffa_pkg::OPCODE_BITS-1:0]);
      req_address <= s_tdata[fffa_pkg::OPCODE_BITS +: ADDRESS_BITS];
      req_size    <= s_tdata[IN_RAW-1 -: SIZE_BITS];
    end
    if (commit) begin
      m_tdata <= OUT_W'({count_next,
                         bytes_free_next[fffa_pkg::FREE_TOTAL_BITS-1:0],
                         found_size, found_address, status});
    end
  end

endmodule

`default_nettype wire

@@ hdl/fffa_checker.sv @@
`default_nettype none

`include "free_list_first_fit_allocator_unit_assert.svh"

module fffa_checker #(
  parameter int unsigned CAPACITY     = fffa_pkg::CAPACITY_DEFAULT,
  parameter int unsigned ADDRESS_BITS = fffa_pkg::ADDRESS_BITS_DEFAULT,
  parameter int unsigned SIZE_BITS    = fffa_pkg::SIZE_BITS_DEFAULT,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1),
  localparam int unsigned OUT_RAW = fffa_pkg::STATUS_BITS + ADDRESS_BITS + SIZE_BITS
                                    + fffa_pkg::FREE_TOTAL_BITS + CNT_W,
  localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  localparam int unsigned ADDR_LO = fffa_pkg::STATUS_BITS;
  localparam int unsigned SIZE_LO = ADDR_LO + ADDRESS_BITS;

  logic [fffa_pkg::STATUS_BITS-1:0] status;
  logic [ADDRESS_BITS-1:0]          found_address;
  logic [SIZE_BITS-1:0]             found_size;
  logic [CNT_W-1:0]                 entry_total;

  assign status        = m_tdata[fffa_pkg::STATUS_BITS-1:0];
  assign found_address = m_tdata[ADDR_LO +: ADDRESS_BITS];
  assign found_size    = m_tdata[SIZE_LO +: SIZE_BITS];
  assign entry_total   = m_tdata[OUT_RAW-1 -: CNT_W];

  `FFFA_ASSERT_NOW(a_status_code, clk, rst, m_tvalid,
    (status == fffa_pkg::STATUS_OK) || (status == fffa_pkg::STATUS_NO_FIT) ||
    (status == fffa_pkg::STATUS_FULL))
  `FFFA_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && (status != fffa_pkg::STATUS_OK),
    (found_address == '0) && (found_size == '0))
  `FFFA_ASSERT_NOW(a_count_bound, clk, rst, m_tvalid, entry_total <= CNT_W'(CAPACITY))
  `FFFA_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  `FFFA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

endmodule

bind free_list_first_fit_allocator_unit fffa_checker #(
  .CAPACITY    (CAPACITY),
  .ADDRESS_BITS(ADDRESS_BITS),
  .SIZE_BITS   (SIZE_BITS)
) u_fffa_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire

@@ dv/free_list_first_fit_allocator_checker.sv @@
`default_nettype none

module free_list_first_fit_allocator_checker
  import fffa_pkg::*;
#(
  localparam int unsigned CAP     = CAPACITY_DEFAULT,
  localparam int unsigned ADDR_W  = ADDRESS_BITS_DEFAULT,
  localparam int unsigned SIZE_W  = SIZE_BITS_DEFAULT,
  localparam int unsigned CNT_W   = $clog2(CAP + 1),
  localparam int unsigned IN_W    = ((OPCODE_BITS + ADDR_W + SIZE_W + 7) / 8) * 8,
  localparam int unsigned OUT_W   = ((STATUS_BITS + ADDR_W + SIZE_W + FREE_TOTAL_BITS
                                      + CNT_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic [ADDR_W-1:0]          found_address;
    logic [SIZE_W-1:0]          found_size;
    logic [FREE_TOTAL_BITS-1:0] free_total;
    logic [CNT_W-1:0]           entry_total;
  } alloc_result_t;

  logic [ADDR_W-1:0]     blk_addr [CAP];
  logic [SIZE_W-1:0]     blk_size [CAP];
  int                    held;
  logic [TOTAL_BITS-1:0] bytes_free;
  alloc_result_t         pending_results [$];
  int                    err_total;

  initial begin
    held = 0;
    bytes_free = '0;
    err_total = 0;
  end

  assign mismatches = err_total;

  function automatic alloc_result_t apply_request(logic [OPCODE_BITS-1:0] opcode,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [SIZE_W-1:0] req);
    alloc_result_t r;
    int            hit;
    bit            front_only;
    r = '0;
    hit = -1;
    front_only = (opcode == OP_OBTAIN_SMALL) || (opcode == OP_LOOKUP_SMALL);
    case (opcode)
      OP_FREE: begin
        if (held >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          blk_addr[held] = addr;
          blk_size[held] = req;
          held = held + 1;
          bytes_free = bytes_free + TOTAL_BITS'(req);
        end
      end
      OP_OBTAIN_SMALL, OP_OBTAIN_LARGE, OP_LOOKUP_SMALL, OP_LOOKUP_LARGE: begin
        if (!(opcode == OP_LOOKUP_LARGE && bytes_free < TOTAL_BITS'(req))) begin
          for (int i = held - 1; i >= 0; i--) begin
            if (blk_size[i] >= req) begin
              hit = i;
              break;
            end
            if (front_only) break;
          end
        end
        if (hit < 0) begin
          r.status = STATUS_NO_FIT;
        end else begin
          r.status = STATUS_OK;
          r.found_address = blk_addr[hit];
          r.found_size = blk_size[hit];
          if (opcode == OP_OBTAIN_SMALL || opcode == OP_OBTAIN_LARGE) begin
            bytes_free = bytes_free - TOTAL_BITS'(blk_size[hit]);
            for (int i = hit; i + 1 < held; i++) begin
              blk_addr[i] = blk_addr[i + 1];
              blk_size[i] = blk_size[i + 1];
            end
            held = held - 1;
          end
        end
      end
      OP_REBUILD: begin
        held = 0;
        bytes_free = '0;
      end
      default: ;
    endcase
    r.free_total = bytes_free[FREE_TOTAL_BITS-1:0];
    r.entry_total = CNT_W'(held);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, field, got, want);
    err_total = err_total + 1;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status        = m_tdata[STATUS_BITS-1:0];
        got.found_address = m_tdata[STATUS_BITS +: ADDR_W];
        got.found_size    = m_tdata[STATUS_BITS + ADDR_W +: SIZE_W];
        got.free_total    = m_tdata[STATUS_BITS + ADDR_W + SIZE_W +: FREE_TOTAL_BITS];
        got.entry_total   = m_tdata[STATUS_BITS + ADDR_W + SIZE_W + FREE_TOTAL_BITS +: CNT_W];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(m_tdata), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.found_address !== want.found_address)
            report_mismatch("found_address", 64'(got.found_address), 64'(want.found_address));
          if (got.found_size !== want.found_size)
            report_mismatch("found_size", 64'(got.found_size), 64'(want.found_size));
          if (got.free_total !== want.free_total)
            report_mismatch("free_total", 64'(got.free_total), 64'(want.free_total));
          if (got.entry_total !== want.entry_total)
            report_mismatch("entry_total", 64'(got.entry_total), 64'(want.entry_total));
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_request(s_tdata[OPCODE_BITS-1:0],
                                                s_tdata[OPCODE_BITS +: ADDR_W],
                                                s_tdata[OPCODE_BITS + ADDR_W +: SIZE_W]));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_free_list_first_fit_allocator_unit.sv @@
`default_nettype none

module tb_free_list_first_fit_allocator_unit;
  import fffa_pkg::*;

  localparam int unsigned ADDR_W = ADDRESS_BITS_DEFAULT;
  localparam int unsigned SIZE_W = SIZE_BITS_DEFAULT;
  localparam int unsigned CNT_W  = $clog2(CAPACITY_DEFAULT + 1);
  localparam int unsigned IN_W   = ((OPCODE_BITS + ADDR_W + SIZE_W + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((STATUS_BITS + ADDR_W + SIZE_W + FREE_TOTAL_BITS
                                     + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;

  localparam int SEG_FILL  = 0;
  localparam int SEG_DRAIN = 1;
  localparam int SEG_MIXED = 2;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  int               mismatches;
  int               outstanding;
  int               cycle_count = 0;
  bit               send_quiet = 1'b0;
  bit               take_quiet = 1'b0;

  free_list_first_fit_allocator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  free_list_first_fit_allocator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] draw_address();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[ADDR_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] draw_size();
    int unsigned pick;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    raw = $urandom();
    if (pick < 15) raw = $urandom_range(0, 15);
    else if (pick < 50) raw = $urandom_range(0, 4095);
    else if (pick < 80) raw = $urandom_range(0, 1 << 20);
    else if (pick >= 95) raw = '1;
    return raw[SIZE_W-1:0];
  endfunction

  function automatic logic [OPCODE_BITS-1:0] pick_opcode(int kind);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case (kind)
      SEG_FILL: begin
        if (pick < 92) return OP_FREE;
        return OPCODE_BITS'($urandom_range(OP_OBTAIN_SMALL, OP_LOOKUP_LARGE));
      end
      SEG_DRAIN: begin
        if (pick < 10) return OP_FREE;
        if (pick < 40) return OP_OBTAIN_LARGE;
        if (pick < 60) return OP_OBTAIN_SMALL;
        if (pick < 80) return OP_LOOKUP_LARGE;
        return OP_LOOKUP_SMALL;
      end
      default: begin
        if (pick < 40) return OP_FREE;
        if (pick < 55) return OP_OBTAIN_LARGE;
        if (pick < 65) return OP_OBTAIN_SMALL;
        if (pick < 77) return OP_LOOKUP_LARGE;
        if (pick < 87) return OP_LOOKUP_SMALL;
        if (pick < 90) return OP_REBUILD;
        if (pick < 93) return OPCODE_BITS'($urandom_range(6, 7));
        return OP_OBTAIN_LARGE;
      end
    endcase
  endfunction

  task automatic send_item(logic [OPCODE_BITS-1:0] opcode, logic [ADDR_W-1:0] addr,
                           logic [SIZE_W-1:0] size);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({size, addr, opcode});
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver: stall per item, with quiet stretches
  initial begin
    int unsigned gap;
    int          taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) take_quiet = ($urandom_range(0, 3) == 0);
      gap = take_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin
    int issued;
    int kind;
    int seg_left;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_OBTAIN_SMALL, draw_address(), '0);
    send_item(OP_LOOKUP_LARGE, draw_address(), '0);
    send_item(OP_FREE, '0, '0);
    send_item(OP_FREE, '1, '1);
    send_item(OP_FREE, 48'h1234_5678_9ABC, 24'h000100);
    send_item(OP_LOOKUP_SMALL, draw_address(), 24'h000100);
    send_item(OP_LOOKUP_SMALL, draw_address(), 24'h000101);
    send_item(OP_OBTAIN_SMALL, draw_address(), 24'h000200);
    send_item(OP_LOOKUP_LARGE, draw_address(), '1);
    send_item(OP_OBTAIN_LARGE, draw_address(), '1);
    // request above the free total
    send_item(OP_LOOKUP_LARGE, draw_address(), 24'h000200);
    send_item(OPCODE_BITS'(6), draw_address(), draw_size());
    send_item(OPCODE_BITS'(7), '1, '1);
    send_item(OP_OBTAIN_SMALL, draw_address(), '0);
    send_item(OP_OBTAIN_LARGE, draw_address(), '0);
    send_item(OP_OBTAIN_LARGE, draw_address(), '0);
    send_item(OP_FREE, draw_address(), draw_size());
    send_item(OP_REBUILD, draw_address(), draw_size());
    send_item(OP_LOOKUP_SMALL, draw_address(), '0);
    send_item(OP_FREE, draw_address(), 24'h000010);
    send_item(OP_OBTAIN_LARGE, draw_address(), 24'h000010);

    // open with a fill long enough to overflow the table
    kind = SEG_FILL;
    seg_left = 90;
    for (issued = 0; issued < RANDOM_ITEMS; issued++) begin
      if (seg_left == 0) begin
        kind = $urandom_range(SEG_FILL, SEG_MIXED);
        seg_left = $urandom_range(30, 100);
      end
      if (issued % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      send_item(pick_opcode(kind), draw_address(), draw_size());
      seg_left--;
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/fffa_pkg.sv
hdl/fffa_cell.sv
hdl/fffa_pick.sv
hdl/free_list_first_fit_allocator_unit.sv
hdl/fffa_checker.sv
dv/free_list_first_fit_allocator_checker.sv
dv/tb_free_list_first_fit_allocator_unit.sv
